// ===== hw/rtl/rvalu_pkg.sv =====
package rvalu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned SHAMT_W = 5;

	// major opcodes, instruction bits 6:2
	localparam logic [4:0] OPC_LOAD   = 5'd0;
	localparam logic [4:0] OPC_OPIMM  = 5'd4;
	localparam logic [4:0] OPC_AUIPC  = 5'd5;
	localparam logic [4:0] OPC_STORE  = 5'd8;
	localparam logic [4:0] OPC_OP     = 5'd12;
	localparam logic [4:0] OPC_LUI    = 5'd13;
	localparam logic [4:0] OPC_BRANCH = 5'd24;
	localparam logic [4:0] OPC_JALR   = 5'd25;
	localparam logic [4:0] OPC_JAL    = 5'd27;

	localparam logic [6:0] FUNCT7_ALT = 7'd32;

	// alu operations by funct3
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// decoded controls from the first stage
	typedef struct packed {
		logic [2:0] funct3;
		logic       use_imm;
		logic       negate;
		logic       arith;
	} dec_t;

	// controls the execute stage needs
	typedef struct packed {
		logic [2:0] funct3;
		logic       arith;
	} exe_t;

	function automatic logic [XLEN-1:0] imm_decode(input logic [XLEN-1:0] insn);
		logic [XLEN-1:0] imm_i;
		logic [XLEN-1:0] imm_s;
		logic [XLEN-1:0] imm_u;
		logic [XLEN-1:0] imm_b;
		logic [XLEN-1:0] imm_j;
		logic [XLEN-1:0] res;
		imm_i = {{21{insn[31]}}, insn[30:20]};
		imm_s = {{21{insn[31]}}, insn[30:25], insn[11:7]};
		imm_u = {insn[31:12], 12'd0};
		imm_b = {{20{insn[31]}}, insn[7], insn[30:25], insn[11:8], 1'b0};
		imm_j = {{12{insn[31]}}, insn[19:12], insn[20], insn[30:21], 1'b0};
		case (insn[6:2])
			OPC_LOAD, OPC_OPIMM, OPC_OP, OPC_JALR: res = imm_i;
			OPC_STORE: res = imm_s;
			OPC_AUIPC, OPC_LUI: res = imm_u;
			OPC_BRANCH: res = imm_b;
			OPC_JAL: res = imm_j;
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

// ===== hw/rtl/rvalu_decode.sv =====
module rvalu_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	output logic                          ready,
	input  logic [rvalu_pkg::XLEN-1:0]    instruction,
	input  logic [rvalu_pkg::XLEN-1:0]    operand_a,
	input  logic [rvalu_pkg::XLEN-1:0]    operand_b,
	input  logic                          next_ready,
	output logic                          valid_s1,
	output rvalu_pkg::dec_t               dec_s1,
	output logic [rvalu_pkg::XLEN-1:0]    a_s1,
	output logic [rvalu_pkg::XLEN-1:0]    b_s1,
	output logic [rvalu_pkg::XLEN-1:0]    imm_s1
);

	rvalu_pkg::dec_t dec_d;
	logic [4:0]      opc;
	logic [6:0]      funct7;

	assign opc    = instruction[6:2];
	assign funct7 = instruction[31:25];
	assign ready  = !valid_s1 || next_ready;

	always_comb begin
		dec_d.funct3  = instruction[14:12];
		dec_d.use_imm = (opc == rvalu_pkg::OPC_OPIMM);
		dec_d.negate  = (opc == rvalu_pkg::OPC_OP) && (instruction[14:12] == rvalu_pkg::F3_ADD)
			&& (funct7 == rvalu_pkg::FUNCT7_ALT);
		dec_d.arith   = (funct7 == rvalu_pkg::FUNCT7_ALT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			dec_s1 <= dec_d;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
			imm_s1 <= rvalu_pkg::imm_decode(instruction);
		end
	end

endmodule

// ===== hw/rtl/rvalu_operand.sv =====
module rvalu_operand (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	output logic                          ready,
	input  rvalu_pkg::dec_t               dec_s1,
	input  logic [rvalu_pkg::XLEN-1:0]    a_s1,
	input  logic [rvalu_pkg::XLEN-1:0]    b_s1,
	input  logic [rvalu_pkg::XLEN-1:0]    imm_s1,
	input  logic                          next_ready,
	output logic                          valid_s2,
	output rvalu_pkg::exe_t               exe_s2,
	output logic [rvalu_pkg::XLEN-1:0]    a_s2,
	output logic [rvalu_pkg::XLEN-1:0]    rhs_s2,
	output logic [rvalu_pkg::XLEN-1:0]    imm_s2
);

	logic [rvalu_pkg::XLEN-1:0] sel;
	logic [rvalu_pkg::XLEN-1:0] rhs_d;

	assign ready = !valid_s2 || next_ready;
	assign sel   = dec_s1.use_imm ? imm_s1 : b_s1;
	// subtract is add of the two's complement
	assign rhs_d = dec_s1.negate ? (~sel + {{(rvalu_pkg::XLEN-1){1'b0}}, 1'b1}) : sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s1) begin
			exe_s2.funct3 <= dec_s1.funct3;
			exe_s2.arith  <= dec_s1.arith;
			a_s2          <= a_s1;
			rhs_s2        <= rhs_d;
			imm_s2        <= imm_s1;
		end
	end

endmodule

// ===== hw/rtl/rvalu_exec.sv =====
module rvalu_exec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	output logic                          ready,
	input  rvalu_pkg::exe_t               exe_s2,
	input  logic [rvalu_pkg::XLEN-1:0]    a_s2,
	input  logic [rvalu_pkg::XLEN-1:0]    rhs_s2,
	input  logic [rvalu_pkg::XLEN-1:0]    imm_s2,
	input  logic                          out_stall,
	output logic                          valid_s3,
	output logic [rvalu_pkg::XLEN-1:0]    alu_s3,
	output logic [rvalu_pkg::XLEN-1:0]    imm_s3
);

	logic [rvalu_pkg::SHAMT_W-1:0] sh;
	logic [rvalu_pkg::XLEN-1:0]    res;

	assign ready = !valid_s3 || !out_stall;
	assign sh    = rhs_s2[rvalu_pkg::SHAMT_W-1:0];

	always_comb begin
		case (exe_s2.funct3)
			rvalu_pkg::F3_ADD:  res = a_s2 + rhs_s2;
			rvalu_pkg::F3_SLL:  res = a_s2 << sh;
			rvalu_pkg::F3_SLT:  res = {{(rvalu_pkg::XLEN-1){1'b0}},
				($signed(a_s2) < $signed(rhs_s2))};
			rvalu_pkg::F3_SLTU: res = {{(rvalu_pkg::XLEN-1){1'b0}}, (a_s2 < rhs_s2)};
			rvalu_pkg::F3_XOR:  res = a_s2 ^ rhs_s2;
			rvalu_pkg::F3_SR:   res = exe_s2.arith ? $unsigned($signed(a_s2) >>> sh)
				: (a_s2 >> sh);
			rvalu_pkg::F3_OR:   res = a_s2 | rhs_s2;
			default:            res = a_s2 & rhs_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s2) begin
			alu_s3 <= res;
			imm_s3 <= imm_s2;
		end
	end

endmodule

// ===== hw/rtl/rv32i_alu_with_immediate_decode_top.sv =====
// channel | handshake           | payload
// --------+---------------------+------------------------------------------
// in      | in_valid, in_stall  | instruction, operand_a, operand_b
// out     | out_valid, out_stall| alu_value, immediate
//
// one transfer per cycle sustained while out_stall is low; each stage below is registered
// stages: immediate decode, operand select and negate, alu and output register
// reset clears the stage valid bits only, the block is ready straight away
// a stall on the output holds the last stage; a stage with a free slot downstream
// keeps moving, so bubbles are squeezed out before in_stall rises
module rv32i_alu_with_immediate_decode_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rvalu_pkg::XLEN-1:0]    instruction,
	input  logic [rvalu_pkg::XLEN-1:0]    operand_a,
	input  logic [rvalu_pkg::XLEN-1:0]    operand_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rvalu_pkg::XLEN-1:0]    alu_value,
	output logic [rvalu_pkg::XLEN-1:0]    immediate
);

	logic                       ready1;
	logic                       ready2;
	logic                       ready3;
	logic                       valid_s1;
	logic                       valid_s2;
	rvalu_pkg::dec_t            dec_s1;
	rvalu_pkg::exe_t            exe_s2;
	logic [rvalu_pkg::XLEN-1:0] a_s1;
	logic [rvalu_pkg::XLEN-1:0] b_s1;
	logic [rvalu_pkg::XLEN-1:0] imm_s1;
	logic [rvalu_pkg::XLEN-1:0] a_s2;
	logic [rvalu_pkg::XLEN-1:0] rhs_s2;
	logic [rvalu_pkg::XLEN-1:0] imm_s2;

	assign in_stall = !ready1;

	rvalu_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid       (in_valid),
		.ready       (ready1),
		.instruction (instruction),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.next_ready  (ready2),
		.valid_s1    (valid_s1),
		.dec_s1      (dec_s1),
		.a_s1        (a_s1),
		.b_s1        (b_s1),
		.imm_s1      (imm_s1)
	);

	rvalu_operand u_operand (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ready      (ready2),
		.dec_s1     (dec_s1),
		.a_s1       (a_s1),
		.b_s1       (b_s1),
		.imm_s1     (imm_s1),
		.next_ready (ready3),
		.valid_s2   (valid_s2),
		.exe_s2     (exe_s2),
		.a_s2       (a_s2),
		.rhs_s2     (rhs_s2),
		.imm_s2     (imm_s2)
	);

	rvalu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.ready     (ready3),
		.exe_s2    (exe_s2),
		.a_s2      (a_s2),
		.rhs_s2    (rhs_s2),
		.imm_s2    (imm_s2),
		.out_stall (out_stall),
		.valid_s3  (out_valid),
		.alu_s3    (alu_value),
		.imm_s3    (immediate)
	);

endmodule
